>>> hdl/mdc_pkg.sv
`timescale 1ns / 1ps
package mdc_pkg;

  localparam int unsigned GRID_SIZE  = 31;
  localparam int unsigned CELLS      = (GRID_SIZE - 1) / 2;
  localparam int unsigned CELL_COUNT = CELLS * CELLS;
  localparam int unsigned CIDX_W     = $clog2(CELLS);
  localparam int unsigned CELL_W     = 2 * CIDX_W;
  localparam int unsigned DEPTH_W    = $clog2(CELL_COUNT + 1);
  localparam int unsigned SADDR_W    = $clog2(CELL_COUNT);
  localparam int unsigned PICK_W     = 8;
  localparam int unsigned COORD_W    = 5;
  localparam int unsigned CALC_W     = CIDX_W + COORD_W + 2;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_STEP    = 1'b1;

  typedef logic [CIDX_W-1:0]  cidx_t;
  typedef logic [CELLS-1:0]   row_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MID,
    ST_RD_DN,
    ST_DECIDE,
    ST_POP,
    ST_RESTART
  } state_e;

  typedef struct packed {
    logic  re;
    cidx_t raddr;
    logic  we;
    cidx_t waddr;
    row_t  wdata;
    logic  clear;
  } vm_ctrl_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    cell_t wdata;
  } stk_ctrl_t;

  function automatic logic [1:0] mod3(logic [PICK_W-1:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic logic [1:0] pick_mod(logic [PICK_W-1:0] v, logic [2:0] cnt);
    logic [1:0] r;
    case (cnt)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = mod3(v);
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] grid_coord(cidx_t idx, logic [1:0] offs);
    logic [CALC_W-1:0] t;
    t = (CALC_W'(idx) << 1) + CALC_W'(offs);
    return t[COORD_W-1:0];
  endfunction

endpackage

>>> hdl/mdc_req_if.sv
`timescale 1ns / 1ps
interface mdc_req_if;
  import mdc_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [PICK_W-1:0] random_pick;

  modport source (output valid, output req_type, output random_pick, input ready);
  modport sink   (input valid, input req_type, input random_pick, output ready);
endinterface

>>> hdl/mdc_res_if.sv
`timescale 1ns / 1ps
interface mdc_res_if;
  import mdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] carved_row;
  logic [COORD_W-1:0] carved_col;
  logic               carved;
  logic               done_res;

  modport source (output valid, output carved_row, output carved_col, output carved,
                  output done_res, input ready);
  modport sink   (input valid, input carved_row, input carved_col, input carved,
                  input done_res, output ready);
endinterface

>>> hdl/maze_dfs_carver.sv
`timescale 1ns / 1ps
// Channel | Port  | Direction | Payload
// --------+-------+-----------+------------------------------------------
// request | req_i | in        | req_type, random_pick
// result  | res_o | out       | carved_row, carved_col, carved, done_res
//
// Carving step: ST_IDLE, ST_RD_MID, ST_RD_DN, ST_DECIDE, and ST_POP too on a backtrack;
// restart: ST_IDLE, ST_RESTART. Three reads of one visited-map port (rows above, at and
// below the current cell) set the step length; a backtrack adds the stack memory read.
// Reset clears the walk to the start cell with an empty stack; row valid bits stand in
// for clearing the visited map, so no clearing pass. A stalled result holds in the output
// register; the next transaction is taken meanwhile and its commit waits for it to free.
module maze_dfs_carver (
  input  logic  clk_i,
  input  logic  rst_ni,
  mdc_req_if.sink   req_i,
  mdc_res_if.source res_o
);
  import mdc_pkg::*;

  state_e state_q, state_d;
  cidx_t  ci_q, ci_d, cj_q, cj_d;
  logic [PICK_W-1:0] pick_q;
  row_t   up_row_q, mid_row_q;

  logic               res_valid_q, res_valid_d;
  logic [COORD_W-1:0] res_row_q, res_row_d, res_col_q, res_col_d;
  logic               res_carved_q, res_carved_d, res_done_q, res_done_d;

  vm_ctrl_t  vm_ctrl;
  row_t      vm_rdata;
  stk_ctrl_t stk_ctrl;
  depth_t    depth;
  cell_t     stk_rdata;

  logic       in_acc, out_free;
  logic [3:0] open_dir;
  logic [2:0] count;
  logic [1:0] k, seen;
  logic       found;
  dir_e       sel;
  logic [CELLS:0] left_sh;
  row_t       right_sh, base_row;
  cidx_t      tci, tcj;
  logic [COORD_W-1:0] wall_row, wall_col;
  logic       step_commit;

  mdc_visit_map u_vmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (vm_ctrl),
    .rdata_o (vm_rdata)
  );

  mdc_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .depth_o (depth),
    .rdata_o (stk_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;

  // neighbor scan and pick
  always_comb begin
    left_sh  = {mid_row_q, 1'b0} >> cj_q;
    right_sh = mid_row_q >> cj_q;
    open_dir[DIR_UP]    = (ci_q != '0) && !up_row_q[cj_q];
    open_dir[DIR_DOWN]  = (({1'b0, ci_q} + 1'b1) < (CIDX_W + 1)'(CELLS)) && !vm_rdata[cj_q];
    open_dir[DIR_LEFT]  = (cj_q != '0) && !left_sh[0];
    open_dir[DIR_RIGHT] = (({1'b0, cj_q} + 1'b1) < (CIDX_W + 1)'(CELLS)) && !right_sh[1];
    count = 3'(open_dir[0]) + 3'(open_dir[1]) + 3'(open_dir[2]) + 3'(open_dir[3]);
    k     = pick_mod(pick_q, count);
    seen  = '0;
    found = 1'b0;
    sel   = DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (open_dir[d] && !found) begin
        if (seen == k) begin
          found = 1'b1;
          sel   = dir_e'(d[1:0]);
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
    tci      = ci_q;
    tcj      = cj_q;
    base_row = mid_row_q;
    wall_row = grid_coord(ci_q, 2'd1);
    wall_col = grid_coord(cj_q, 2'd1);
    unique case (sel)
      DIR_UP: begin
        tci      = ci_q - 1'b1;
        base_row = up_row_q;
        wall_row = grid_coord(ci_q, 2'd0);
      end
      DIR_DOWN: begin
        tci      = ci_q + 1'b1;
        base_row = vm_rdata;
        wall_row = grid_coord(ci_q, 2'd2);
      end
      DIR_LEFT: begin
        tcj      = cj_q - 1'b1;
        wall_col = grid_coord(cj_q, 2'd0);
      end
      default: begin
        tcj      = cj_q + 1'b1;
        wall_col = grid_coord(cj_q, 2'd2);
      end
    endcase
  end

  assign step_commit = (state_q == ST_DECIDE) && (count != '0) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (req_i.req_type == REQ_STEP) ? ST_RD_MID : ST_RESTART;
        end
      end
      ST_RD_MID: state_d = ST_RD_DN;
      ST_RD_DN:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (count == '0 && depth != '0) begin
          state_d = ST_POP;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESTART: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    vm_ctrl      = '0;
    stk_ctrl     = '0;
    ci_d         = ci_q;
    cj_d         = cj_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    res_carved_d = res_carved_q;
    res_done_d   = res_done_q;
    stk_ctrl.wdata = {ci_q, cj_q};
    vm_ctrl.wdata  = base_row | (row_t'(1) << tcj);
    vm_ctrl.waddr  = tci;
    unique case (state_q)
      ST_IDLE: begin
        vm_ctrl.re    = in_acc && (req_i.req_type == REQ_STEP);
        vm_ctrl.raddr = (ci_q == '0) ? ci_q : ci_q - 1'b1;
      end
      ST_RD_MID: begin
        vm_ctrl.re    = 1'b1;
        vm_ctrl.raddr = ci_q;
      end
      ST_RD_DN: begin
        vm_ctrl.re    = 1'b1;
        vm_ctrl.raddr = (({1'b0, ci_q} + 1'b1) < (CIDX_W + 1)'(CELLS)) ? ci_q + 1'b1 : ci_q;
      end
      ST_DECIDE: begin
        if (step_commit) begin
          vm_ctrl.we    = 1'b1;
          stk_ctrl.push = 1'b1;
          ci_d          = tci;
          cj_d          = tcj;
          res_valid_d   = 1'b1;
          res_row_d     = wall_row;
          res_col_d     = wall_col;
          res_carved_d  = 1'b1;
          res_done_d    = 1'b0;
        end else if (count == '0 && depth != '0) begin
          stk_ctrl.pop = 1'b1;
        end else if (count == '0 && out_free) begin
          res_valid_d  = 1'b1;
          res_row_d    = '0;
          res_col_d    = '0;
          res_carved_d = 1'b0;
          res_done_d   = 1'b1;
        end
      end
      ST_POP: begin
        if (out_free) begin
          ci_d         = stk_rdata[CELL_W-1:CIDX_W];
          cj_d         = stk_rdata[CIDX_W-1:0];
          res_valid_d  = 1'b1;
          res_row_d    = '0;
          res_col_d    = '0;
          res_carved_d = 1'b0;
          res_done_d   = (depth == '0);
        end
      end
      ST_RESTART: begin
        if (out_free) begin
          vm_ctrl.clear  = 1'b1;
          stk_ctrl.clear = 1'b1;
          ci_d           = '0;
          cj_d           = '0;
          res_valid_d    = 1'b1;
          res_row_d      = '0;
          res_col_d      = '0;
          res_carved_d   = 1'b0;
          res_done_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ci_q        <= '0;
      cj_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ci_q        <= ci_d;
      cj_q        <= cj_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pick_q <= req_i.random_pick;
    end
    if (state_q == ST_RD_MID) begin
      up_row_q <= vm_rdata;
    end
    if (state_q == ST_RD_DN) begin
      mid_row_q <= vm_rdata;
    end
    res_row_q    <= res_row_d;
    res_col_q    <= res_col_d;
    res_carved_q <= res_carved_d;
    res_done_q   <= res_done_d;
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.carved_row = res_row_q;
  assign res_o.carved_col = res_col_q;
  assign res_o.carved     = res_carved_q;
  assign res_o.done_res   = res_done_q;

`ifndef NO_ASSERTIONS
  a_pop_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> $past(state_q) == ST_DECIDE || $past(state_q) == ST_POP)
    else $error("backtrack without a scan");
  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ci_q <= CIDX_W'(CELLS - 1) && cj_q <= CIDX_W'(CELLS - 1))
    else $error("current cell outside the grid");
`endif

endmodule

>>> hdl/mdc_ram.sv
`timescale 1ns / 1ps
module mdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mdc_visit_map.sv
`timescale 1ns / 1ps
module mdc_visit_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdc_pkg::vm_ctrl_t ctrl_i,
  output mdc_pkg::row_t     rdata_o
);
  import mdc_pkg::*;

  row_t  valid_q, valid_d;
  logic  rd_valid_q;
  cidx_t rd_addr_q;
  row_t  ram_rdata;

  mdc_ram #(
    .WIDTH (CELLS),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (ctrl_i.waddr),
    .wdata_i (ctrl_i.wdata),
    .re_i    (ctrl_i.re),
    .raddr_i (ctrl_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = '0;
    end else if (ctrl_i.we) begin
      valid_d[ctrl_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rd_valid_q <= valid_q[ctrl_i.raddr];
      rd_addr_q  <= ctrl_i.raddr;
    end
  end

  // an unwritten row reads as cleared, the start cell excepted
  assign rdata_o = rd_valid_q ? ram_rdata : ((rd_addr_q == '0) ? row_t'(1) : '0);

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.we |-> !ctrl_i.re && !ctrl_i.clear)
    else $error("visited map written while read or cleared");
`endif

endmodule

>>> hdl/mdc_stack.sv
`timescale 1ns / 1ps
module mdc_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdc_pkg::stk_ctrl_t ctrl_i,
  output mdc_pkg::depth_t    depth_o,
  output mdc_pkg::cell_t     rdata_o
);
  import mdc_pkg::*;

  depth_t depth_q, depth_d;
  depth_t depth_m1;
  logic   full;
  logic   do_push;

  assign depth_m1 = depth_q - 1'b1;
  assign full     = (depth_q >= DEPTH_W'(CELL_COUNT));
  assign do_push  = ctrl_i.push && !full;

  mdc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (depth_q[SADDR_W-1:0]),
    .wdata_i (ctrl_i.wdata),
    .re_i    (ctrl_i.pop),
    .raddr_i (depth_m1[SADDR_W-1:0]),
    .rdata_o (rdata_o)
  );

  always_comb begin
    depth_d = depth_q;
    if (ctrl_i.clear) begin
      depth_d = '0;
    end else if (do_push) begin
      depth_d = depth_q + 1'b1;
    end else if (ctrl_i.pop) begin
      depth_d = depth_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign depth_o = depth_q;

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> depth_q != '0)
    else $error("pop from empty stack");
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("push and pop in one cycle");
`endif

endmodule
